/* hw/rtl/rmt_pkg.sv */
// Package for the range-minimum segment tree core.
// Holds the widths, codes, state enum and the structs shared between the
// top level and the tree walker. No dependencies.
package rmt_pkg;

   localparam int LEAVES      = 1024;
   localparam int POS_W       = 10;
   localparam int LEN_W       = 11;
   localparam int DATA_W      = 32;
   localparam int NODE_AW     = $clog2(LEAVES) + 1;
   localparam int NODE_DEPTH  = 2 * LEAVES;
   localparam int STACK_DEPTH = 16;
   localparam int STK_AW      = $clog2(STACK_DEPTH);
   localparam int SP_W        = STK_AW + 1;
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 32;
   localparam int CSR_TDATA_W = 16;

   localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LEAVES);
   localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(1);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WR_DOWN,
      ST_WR_UP,
      ST_QRY,
      ST_FIN
   } walk_state_type;

   typedef struct packed {
      logic                     op;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         range_low;
      logic [POS_W-1:0]         range_high;
   } walk_cmd_type;

   typedef struct packed {
      logic [NODE_AW-1:0] idx;
      logic [POS_W-1:0]   lo;
      logic [POS_W-1:0]   hi;
   } node_entry_type;

   typedef struct packed {
      logic               rd_en;
      logic [NODE_AW-1:0] rd_addr;
      logic               wr_en;
      logic [NODE_AW-1:0] wr_addr;
      logic [DATA_W-1:0]  wr_data;
   } mem_req_type;

   typedef struct packed {
      logic idle;
      logic done;
   } walk_status_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] minimum;
      logic                     empty_range;
   } walk_result_type;

endpackage

/* hw/rtl/rmt_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module rmt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/rmt_walker.sv */
// Tree walker: leaf write with path refresh, and range-minimum traversal.
// Uses rmt_pkg; drives the node memory through an rmt_pkg::mem_req_type port.
module rmt_walker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  rmt_pkg::walk_cmd_type          cmd,
   input  logic [rmt_pkg::LEN_W-1:0]      used_length,
   input  logic                           out_free,
   output rmt_pkg::mem_req_type           mem_req,
   input  logic [rmt_pkg::DATA_W-1:0]     mem_rd_data,
   output rmt_pkg::walk_status_type       status,
   output rmt_pkg::walk_result_type       result
);

   import rmt_pkg::*;

   walk_state_type           state_ff, state_in;
   walk_cmd_type             cmd_ff, cmd_in;
   node_entry_type           cur_ff, cur_in;
   logic signed [DATA_W-1:0] acc_ff, acc_in;
   logic                     pend_ff, pend_in;
   logic                     empty_ff, empty_in;
   logic [SP_W-1:0]          sp_ff, sp_in;
   node_entry_type           stack_ff [STACK_DEPTH];

   logic                     push_en;
   node_entry_type           push_entry;
   logic [SP_W-1:0]          sp_dec;
   node_entry_type           top_entry;
   logic signed [DATA_W-1:0] rd_val;
   logic signed [DATA_W-1:0] fold;
   logic signed [DATA_W-1:0] up_min;
   logic [POS_W-1:0]         mid;
   logic [POS_W-1:0]         last_pos;
   logic [NODE_AW-1:0]       left_idx;
   logic [NODE_AW-1:0]       right_idx;
   logic [NODE_AW-1:0]       par_idx;
   logic                     covered;
   logic                     disjoint;
   logic                     qry_empty;
   logic                     done;

   function automatic logic [NODE_AW-1:0] sibling_of(input logic [NODE_AW-1:0] i);
      return i[0] ? NODE_AW'(i + 1'b1) : NODE_AW'(i - 1'b1);
   endfunction

   assign rd_val    = mem_rd_data;
   assign fold      = (pend_ff && (rd_val < acc_ff)) ? rd_val : acc_ff;
   assign up_min    = (rd_val < acc_ff) ? rd_val : acc_ff;
   assign mid       = POS_W'(({1'b0, cur_ff.lo} + {1'b0, cur_ff.hi}) >> 1);
   assign last_pos  = POS_W'(used_length - 1'b1);
   assign left_idx  = NODE_AW'({cur_ff.idx, 1'b0} + 1'b1);
   assign right_idx = NODE_AW'({cur_ff.idx, 1'b0} + 2'd2);
   assign par_idx   = NODE_AW'((cur_ff.idx - 1'b1) >> 1);
   assign covered   = (cur_ff.lo >= cmd_ff.range_low) && (cur_ff.hi <= cmd_ff.range_high);
   assign disjoint  = (cmd_ff.range_low > cur_ff.hi) || (cmd_ff.range_high < cur_ff.lo);
   assign qry_empty = (cmd.range_low > cmd.range_high)
                      || ({1'b0, cmd.range_low} >= used_length);
   assign sp_dec    = sp_ff - 1'b1;
   assign top_entry = stack_ff[sp_dec[STK_AW-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
         sp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         sp_ff    <= sp_in;
      end
      cmd_ff   <= cmd_in;
      cur_ff   <= cur_in;
      acc_ff   <= acc_in;
      empty_ff <= empty_in;
      if (push_en) begin
         stack_ff[sp_ff[STK_AW-1:0]] <= push_entry;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      cur_in     = cur_ff;
      acc_in     = acc_ff;
      pend_in    = 1'b0;
      empty_in   = empty_ff;
      sp_in      = sp_ff;
      push_en    = 1'b0;
      push_entry = '{idx: right_idx, lo: POS_W'(mid + 1'b1), hi: cur_ff.hi};
      mem_req    = '0;
      done       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in = cmd;
               acc_in = INT_MAX;
               cur_in = '{idx: '0, lo: '0, hi: last_pos};
               sp_in  = '0;
               if (cmd.op == OP_WRITE) begin
                  state_in = ST_WR_DOWN;
               end else if (qry_empty) begin
                  empty_in = 1'b1;
                  state_in = ST_FIN;
               end else begin
                  empty_in = 1'b0;
                  state_in = ST_QRY;
               end
            end
         end

         ST_WR_DOWN: begin
            priority if ({1'b0, cmd_ff.position} >= used_length) begin
               state_in = ST_IDLE;
            end else if (cur_ff.lo >= cur_ff.hi) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = cur_ff.idx;
               mem_req.wr_data = cmd_ff.value;
               acc_in          = cmd_ff.value;
               if (cur_ff.idx == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = sibling_of(cur_ff.idx);
                  state_in        = ST_WR_UP;
               end
            end else if (cmd_ff.position <= mid) begin
               cur_in = '{idx: left_idx, lo: cur_ff.lo, hi: mid};
            end else begin
               cur_in = '{idx: right_idx, lo: POS_W'(mid + 1'b1), hi: cur_ff.hi};
            end
         end

         ST_WR_UP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = par_idx;
            mem_req.wr_data = up_min;
            acc_in          = up_min;
            cur_in.idx      = par_idx;
            if (par_idx == '0) begin
               state_in = ST_IDLE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = sibling_of(par_idx);
            end
         end

         ST_QRY: begin
            acc_in = fold;
            if (covered || disjoint || (cur_ff.lo >= cur_ff.hi)) begin
               if (covered) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = cur_ff.idx;
                  pend_in         = 1'b1;
               end
               if (sp_ff == '0) begin
                  state_in = ST_FIN;
               end else begin
                  cur_in = top_entry;
                  sp_in  = sp_dec;
               end
            end else begin
               push_en = 1'b1;
               sp_in   = SP_W'(sp_ff + 1'b1);
               cur_in  = '{idx: left_idx, lo: cur_ff.lo, hi: mid};
            end
         end

         ST_FIN: begin
            acc_in = fold;
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign status.idle          = (state_ff == ST_IDLE);
   assign status.done          = done;
   assign result.minimum       = fold;
   assign result.empty_range   = empty_ff;

endmodule

/* hw/rtl/range_minimum_tree_core.sv */
// Range-minimum segment tree core: top level with stream ports, length register
// and result register. Uses rmt_pkg, rmt_walker and rmt_ram.
//
// Usage:
//   req channel: one transfer per operation. req_tuser[0] selects a write
//   (0) or a range-minimum query (1). A write to a position below used_length
//   stores value there and refreshes the minima up to the root; it returns
//   nothing. A query returns one transfer on the rsp channel: the minimum over
//   range_low..range_high in rsp_tdata, and rsp_tuser[0] set when no element
//   of the range is in use (rsp_tdata then holds 2147483647).
//   csr channel: writes used_length (saturated to 1..1024); write it only
//   while the core is idle, then rewrite the elements before querying.
// Timing: one operation at a time. A write walks down the tree to the leaf,
//   then back up one level at a time, refreshing each parent from the
//   sibling read through the node RAM's single read port. A query visits one
//   node per cycle, at most four per level, then folds the last read in the
//   walker's final state and passes the result to the result register for rsp.
// Reset: used_length returns to 1024; node RAM contents stay undefined until
//   written. A stalled rsp holds its result; the walker then waits in its final
//   state and req_tready stays low until the result register frees up.
module range_minimum_tree_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [9:0] position, [41:10] value, [51:42] range_low, [61:52] range_high
   input  logic [rmt_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [0] op
   input  logic [0:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [31:0] minimum
   output logic [rmt_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // [0] empty_range
   output logic [0:0]                       rsp_tuser,
   input  logic                             csr_tvalid,
   output logic                             csr_tready,
   // [10:0] used_length
   input  logic [rmt_pkg::CSR_TDATA_W-1:0]  csr_tdata
);

   import rmt_pkg::*;

   logic [LEN_W-1:0]         len_ff, len_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_min_ff;
   logic                     rsp_empty_ff;

   logic [LEN_W-1:0]         csr_raw;
   logic                     start;
   logic                     out_free;
   walk_cmd_type             cmd;
   mem_req_type              mem_req;
   logic [DATA_W-1:0]        mem_rd_data;
   walk_status_type          status;
   walk_result_type          result;

   assign csr_tready = 1'b1;
   assign csr_raw    = csr_tdata[LEN_W-1:0];

   always_comb begin
      len_in = len_ff;
      if (csr_tvalid && csr_tready) begin
         priority if (csr_raw < LEN_MIN) begin
            len_in = LEN_MIN;
         end else if (csr_raw > LEN_MAX) begin
            len_in = LEN_MAX;
         end else begin
            len_in = csr_raw;
         end
      end
   end

   assign cmd.op         = req_tuser[0];
   assign cmd.position   = req_tdata[9:0];
   assign cmd.value      = req_tdata[41:10];
   assign cmd.range_low  = req_tdata[51:42];
   assign cmd.range_high = req_tdata[61:52];

   assign req_tready = status.idle;
   assign start      = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (status.done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= LEN_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (status.done) begin
         rsp_min_ff   <= result.minimum;
         rsp_empty_ff <= result.empty_range;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_min_ff;
   assign rsp_tuser[0] = rsp_empty_ff;

   rmt_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .cmd         (cmd),
      .used_length (len_ff),
      .out_free    (out_free),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data),
      .status      (status),
      .result      (result)
   );

   rmt_ram #(
      .WIDTH (DATA_W),
      .DEPTH (NODE_DEPTH)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

/* hw/rtl/rmt_checker.sv */
// Port-level checker for range_minimum_tree_core, attached by bind.
// Uses rmt_pkg for port widths.
module rmt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [rmt_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [0:0]                       rsp_tuser
);

   import rmt_pkg::*;

   a_rsp_idle_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp transfer changed");

   a_empty_sentinel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == RSP_TDATA_W'(INT_MAX))
      else $error("empty range without sentinel value");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready high the cycle after a transfer");

endmodule

bind range_minimum_tree_core rmt_checker u_rmt_checker (.*);
